### rtl/deq_pkg.sv
// Package for the double-ended queue core: payload structs, command codes,
// controller state type and controller/datapath signal groups. No dependencies.
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int COUNT_W       = 6;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP_REV   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     has_data;
    logic                     last;
    logic [COUNT_W-1:0]       entry_count;
    logic                     dropped;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic exec;
    logic dump_start;
    logic rd_issue;
    logic dump_load;
  } ctrl_t;

  typedef struct packed {
    logic is_dump;
    logic occ_zero;
    logic out_stall;
    logic last_entry;
  } status_t;

endpackage

`default_nettype wire

### rtl/deq_ctrl.sv
// Controller state machine for the double-ended queue core.
// Depends on deq_pkg for the state type and the command and status structs.
`default_nettype none

module deq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire deq_pkg::status_t status,
  output deq_pkg::ctrl_t        ctrl
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (in_valid && !status.out_stall && status.is_dump && !status.occ_zero) begin
          state_next = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        state_next = deq_pkg::ST_SEND;
      end
      deq_pkg::ST_SEND: begin
        if (!status.out_stall) begin
          state_next = status.last_entry ? deq_pkg::ST_IDLE : deq_pkg::ST_READ;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        in_ready = !status.out_stall;
        if (in_valid && !status.out_stall) begin
          if (status.is_dump && !status.occ_zero) begin
            ctrl.dump_start = 1'b1;
          end else begin
            ctrl.exec = 1'b1;
          end
        end
      end
      deq_pkg::ST_READ: begin
        ctrl.rd_issue = 1'b1;
      end
      deq_pkg::ST_SEND: begin
        ctrl.dump_load = !status.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/deq_dp.sv
// Datapath for the double-ended queue core: ring store, front pointer,
// occupancy, dump walker and output register. Depends on deq_pkg.
`default_nettype none

module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire deq_pkg::in_t     in_payload,
  input  wire deq_pkg::ctrl_t   ctrl,
  output deq_pkg::status_t      status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output deq_pkg::out_t         out_payload
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_W   = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data;

  logic [IW-1:0] front;
  logic [CW-1:0] occupancy;
  logic [IW-1:0] idx;
  logic          reverse;

  logic [IW-1:0] front_next;
  logic [CW-1:0] occ_next;
  logic [IW-1:0] back_slot;
  logic [IW-1:0] pop_slot;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] rd_off;
  logic [IW-1:0] rd_addr;
  logic          full;
  logic          is_push;
  logic          dropped;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IW-1:0];
  endfunction

  assign full      = (occupancy == DEPTH_C);
  assign back_slot = wrap_add(front, occupancy[IW-1:0]);
  assign pop_slot  = wrap_add(front, IW'(1));
  assign front_dec = (front == '0) ? LAST_SLOT : front - IW'(1);
  assign is_push   = (in_payload.cmd == deq_pkg::CMD_PUSH_FRONT) ||
                     (in_payload.cmd == deq_pkg::CMD_PUSH_BACK);
  assign dropped   = is_push && full;

  always_comb begin
    front_next = front;
    occ_next   = occupancy;
    wr_en      = 1'b0;
    wr_addr    = back_slot;
    unique case (in_payload.cmd)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (!full) begin
          front_next = front_dec;
          occ_next   = occupancy + CW'(1);
          wr_en      = 1'b1;
          wr_addr    = front_dec;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (!full) begin
          occ_next = occupancy + CW'(1);
          wr_en    = 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (occupancy != '0) begin
          front_next = pop_slot;
          occ_next   = occupancy - CW'(1);
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (occupancy != '0) begin
          occ_next = occupancy - CW'(1);
        end
      end
      default: begin
        occ_next = occupancy;
      end
    endcase
  end

  assign rd_off  = reverse ? IW'(occupancy - CW'(1) - CW'(idx)) : idx;
  assign rd_addr = wrap_add(front, rd_off);

  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[wr_addr] <= in_payload.value;
    end
    if (ctrl.rd_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      occupancy <= '0;
      idx       <= '0;
      reverse   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        front     <= front_next;
        occupancy <= occ_next;
      end
      if (ctrl.dump_start) begin
        idx     <= '0;
        reverse <= (in_payload.cmd == deq_pkg::CMD_DUMP_REV);
      end else if (ctrl.dump_load) begin
        idx <= idx + IW'(1);
      end
      if (ctrl.exec || ctrl.dump_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_payload.data        <= '0;
      out_payload.has_data    <= 1'b0;
      out_payload.last        <= 1'b1;
      out_payload.entry_count <= deq_pkg::COUNT_W'(occ_next);
      out_payload.dropped     <= dropped;
    end else if (ctrl.dump_load) begin
      out_payload.data        <= rd_data;
      out_payload.has_data    <= 1'b1;
      out_payload.last        <= status.last_entry;
      out_payload.entry_count <= deq_pkg::COUNT_W'(occupancy);
      out_payload.dropped     <= 1'b0;
    end
  end

  assign status.is_dump    = (in_payload.cmd == deq_pkg::CMD_DUMP_FWD) ||
                             (in_payload.cmd == deq_pkg::CMD_DUMP_REV);
  assign status.occ_zero   = (occupancy == '0);
  assign status.out_stall  = out_valid && !out_ready;
  assign status.last_entry = (CW'(idx) + CW'(1) == occupancy);

endmodule

`default_nettype wire

### rtl/double_ended_queue_core.sv
// Top level of the double-ended queue core: joins the controller and the datapath.
// Depends on deq_pkg, deq_ctrl and deq_dp.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_payload  (deq_pkg::in_t: cmd, value)
//   out      out_valid / out_ready  out_payload (deq_pkg::out_t: data, has_data,
//                                               last, entry_count, dropped)
//
// A push, pop or empty dump is carried out in the cycle that accepts it and gives
// its status transaction from the output register on the next cycle.
// A dump of N entries runs through the accepting cycle, then for each entry the
// READ state for the registered read of the ring store and the SEND state to
// load the output register.
// Input is taken only while the controller is idle and the output register is
// free or being emptied; a stalled output holds the dump walk where it is.
// Reset empties the queue at once; the ring store needs no clearing pass.
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire deq_pkg::in_t  in_payload,
  output logic               out_valid,
  input  wire logic          out_ready,
  output deq_pkg::out_t      out_payload
);

  deq_pkg::ctrl_t   ctrl;
  deq_pkg::status_t status;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_payload  (in_payload),
    .ctrl        (ctrl),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

### tb/double_ended_queue_core_tb.sv
// Self-checking testbench for double_ended_queue_core: random and directed command traffic
// on a valid/ready input, a randomly stalled output, and a class that models the deque.
// Depends on deq_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS   = 310;
  localparam int QUIET_TAIL     = 50;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef enum {FILLING, DRAINING, MIXED} traffic_mix_t;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned head = 0;
    int unsigned count = 0;
    out_t pending_replies [$];
    int errors = 0;

    function void apply_command(in_t item);
      out_t reply;
      int unsigned off;
      int unsigned i;
      logic refused;
      refused = 1'b0;
      case (item.cmd)
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            refused = 1'b1;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = item.value;
            count++;
          end
        end
        CMD_PUSH_BACK: begin
          if (count >= DEPTH) begin
            refused = 1'b1;
          end else begin
            slots[(head + count) % DEPTH] = item.value;
            count++;
          end
        end
        CMD_POP_FRONT: begin
          if (count != 0) begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        CMD_POP_BACK: begin
          if (count != 0) count--;
        end
        CMD_DUMP_FWD, CMD_DUMP_REV: begin
          if (count == 0) begin
            reply = '0;
            reply.last = 1'b1;
            pending_replies = {pending_replies, reply};
          end else begin
            for (i = 0; i < count; i++) begin
              off = (item.cmd == CMD_DUMP_FWD) ? i : count - 1 - i;
              reply = '0;
              reply.data = slots[(head + off) % DEPTH];
              reply.has_data = 1'b1;
              reply.last = (i + 1 == count);
              reply.entry_count = COUNT_W'(count);
              pending_replies = {pending_replies, reply};
            end
          end
          return;
        end
        default: ;
      endcase
      reply = '0;
      reply.last = 1'b1;
      reply.entry_count = COUNT_W'(count);
      reply.dropped = refused;
      pending_replies = {pending_replies, reply};
    endfunction

    function void match_reply(out_t got);
      out_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected transaction: data=%0d has_data=%0b last=%0b count=%0d dropped=%0b",
                   got.data, got.has_data, got.last, got.entry_count, got.dropped);
        return;
      end
      want = pending_replies[0];
      pending_replies.delete(0);
      if (got.data !== want.data || got.has_data !== want.has_data ||
          got.last !== want.last || got.entry_count !== want.entry_count ||
          got.dropped !== want.dropped) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected data=%0d has_data=%0b last=%0b count=%0d dropped=%0b",
                   want.data, want.has_data, want.last, want.entry_count, want.dropped);
          $display("          actual   data=%0d has_data=%0b last=%0b count=%0d dropped=%0b",
                   got.data, got.has_data, got.last, got.entry_count, got.dropped);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_payload;

  logic quiet = 1'b0;
  logic hold_off_pending = 1'b0;
  int   stalled_cycles = 0;
  deque_scoreboard sb = new();

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload(out_payload)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      stalled_cycles <= 0;
    end else begin
      if (out_valid && out_ready) sb.match_reply(out_payload);
      if (in_valid && in_ready) sb.apply_command(in_payload);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin
    int burst;
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= '{cmd: cmd, value: value};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_directed();
    offer(CMD_DUMP_FWD, 32'h0);
    offer(CMD_DUMP_REV, 32'h1234_5678);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'hFFFF_FFFF);
    offer(CMD_SPARE_LO, 32'hFFFF_FFFF);
    offer(CMD_SPARE_HI, 32'h0);
    offer(CMD_PUSH_FRONT, 32'h8000_0000);
    offer(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    offer(CMD_PUSH_BACK, 32'h0);
    offer(CMD_PUSH_FRONT, 32'h1);
    offer(CMD_DUMP_FWD, 32'h0);
    offer(CMD_DUMP_REV, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'h0);
    offer(CMD_DUMP_FWD, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_POP_BACK, 32'h0);
    offer(CMD_POP_FRONT, 32'h0);
    offer(CMD_DUMP_REV, 32'h0);
    offer(CMD_PUSH_BACK, 32'h5555_5555);
    offer(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    offer(CMD_DUMP_FWD, 32'h0);
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned phase_left;
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    traffic_mix_t mix;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] value;
    sent = 0;
    phase_left = 60;
    mix = FILLING;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mix = traffic_mix_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 60);
      end
      case (mix)
        FILLING: begin
          push_pct = 85;
          pop_pct = 5;
        end
        DRAINING: begin
          push_pct = 10;
          pop_pct = 75;
        end
        default: begin
          push_pct = 35;
          pop_pct = 35;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (roll < push_pct + pop_pct)
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      else if (roll < 96)
        cmd = $urandom_range(0, 1) ? CMD_DUMP_REV : CMD_DUMP_FWD;
      else
        cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      value = $urandom();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'hFFFF_FFFF;
          default: value = 32'h0;
        endcase
      end
      if (sent == HOLD_AT) hold_off_pending = 1'b1;
      quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      offer(cmd, value);
      sent++;
      phase_left--;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_tb.sv
